// ===== hw/rtl/dcmo_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcmo_pkg
// shared widths and rounding/saturation helpers for the matrix normalizer
// ----------------------------------------------------------------------------
package dcmo_pkg;

    localparam int FRAC_BITS = 16;
    localparam int ELEM_W    = 18;
    localparam int PROD_W    = 2 * ELEM_W;
    localparam int SUM_W     = PROD_W + 2;
    localparam int ERR_W     = SUM_W - FRAC_BITS;
    localparam int EPROD_W   = ERR_W + ELEM_W;
    localparam int TDATA_W   = 168;

    typedef logic signed [ELEM_W-1:0] elem_t;
    typedef elem_t row_t [3];

    localparam logic signed [ELEM_W-1:0] ELEM_MAX = {1'b0, {(ELEM_W-1){1'b1}}};
    localparam logic signed [ELEM_W-1:0] ELEM_MIN = {1'b1, {(ELEM_W-1){1'b0}}};

    // floor((v + 2^(FRAC_BITS-1)) / 2^FRAC_BITS) on a sum-width value
    function automatic logic signed [SUM_W-1:0] rnd_f(input logic signed [SUM_W-1:0] v);
        logic signed [SUM_W-1:0] x;
        x = v + (SUM_W'(1) <<< (FRAC_BITS - 1));
        return x >>> FRAC_BITS;
    endfunction

    // same with one extra bit of shift for the halving
    function automatic logic signed [SUM_W-1:0] rnd_h(input logic signed [SUM_W-1:0] v);
        logic signed [SUM_W-1:0] x;
        x = v + (SUM_W'(1) <<< FRAC_BITS);
        return x >>> (FRAC_BITS + 1);
    endfunction

    function automatic elem_t sat(input logic signed [SUM_W-1:0] v);
        if (v > SUM_W'(ELEM_MAX)) begin
            return ELEM_MAX;
        end else if (v < SUM_W'(ELEM_MIN)) begin
            return ELEM_MIN;
        end
        return v[ELEM_W-1:0];
    endfunction

endpackage

// ===== hw/rtl/dcmo_renorm.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcmo_renorm
// three-stage row scaling by (3 - |v|^2)/2 with saturation, stall by enable
// ----------------------------------------------------------------------------
module dcmo_renorm
    import dcmo_pkg::*;
(
    input  logic  aclk,
    input  logic  en,
    input  elem_t v_in [3],
    output elem_t v_out [3]
);

    logic signed [PROD_W-1:0] sq_reg [3];
    elem_t v1_reg [3], v2_reg [3];
    logic signed [ERR_W-1:0] k_reg;
    logic signed [SUM_W-1:0] k_next;
    logic signed [SUM_W-1:0] three;

    assign three = SUM_W'(3) <<< (2 * FRAC_BITS);
    assign k_next = rnd_h(three - (SUM_W'(sq_reg[0]) + SUM_W'(sq_reg[1])
                    + SUM_W'(sq_reg[2])));

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                sq_reg[i] <= PROD_W'(v_in[i]) * PROD_W'(v_in[i]);
                v1_reg[i] <= v_in[i];
                v2_reg[i] <= v1_reg[i];
                v_out[i]  <= sat(rnd_f(SUM_W'(k_reg) * SUM_W'(v2_reg[i])));
            end
            k_reg <= ERR_W'(k_next);
        end
    end

endmodule

// ===== hw/rtl/dcm_orthonormalize_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcm_orthonormalize_unit
// re-orthonormalizes a 3x3 rotation matrix of signed q2.16 elements
// ----------------------------------------------------------------------------
//  channel   dir   payload
//  s_axis    in    nine elements, row-major, 18 bits each in tdata
//  m_axis    out   nine normalized elements, same packing
//
//  one matrix per cycle while m_axis is not stalled; the pipeline
//  depth is set by dot product, error correction, cross product and scaling
//  stages, each at most one multiplier deep
//  reset clears valid bits only; a stall freezes the whole pipeline
// ----------------------------------------------------------------------------
module dcm_orthonormalize_unit
    import dcmo_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    // in_r0c0, in_r0c1, in_r0c2, in_r1c0 .. in_r2c2, zero pad
    input  logic [TDATA_W-1:0] s_axis_tdata,
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    // out_r0c0, out_r0c1, out_r0c2, out_r1c0 .. out_r2c2, zero pad
    output logic [TDATA_W-1:0] m_axis_tdata
);

    localparam int DEPTH = 9;

    logic [DEPTH-1:0] vld_reg;
    logic             en;

    assign en            = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = en;
    assign m_axis_tvalid = vld_reg[DEPTH-1];

    elem_t r0 [3], r1 [3];
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            r0[i] = s_axis_tdata[i*ELEM_W +: ELEM_W];
            r1[i] = s_axis_tdata[(i+3)*ELEM_W +: ELEM_W];
        end
    end

    // stage 1: products of dot(row0,row1)
    logic signed [PROD_W-1:0] p1_reg [3];
    elem_t a1_reg [3], b1_reg [3];
    // stage 2: error
    logic signed [ERR_W-1:0] err_reg;
    elem_t a2_reg [3], b2_reg [3];
    // stage 3: error products
    logic signed [EPROD_W-1:0] ea_reg [3], eb_reg [3];
    elem_t a3_reg [3], b3_reg [3];
    // stage 4: corrected rows
    elem_t a4_reg [3], b4_reg [3];
    // stage 5: cross products terms
    logic signed [PROD_W-1:0] xp_reg [3], xn_reg [3];
    elem_t a5_reg [3], b5_reg [3];
    // stage 6: third row
    elem_t a6_reg [3], b6_reg [3], c6_reg [3];

    logic signed [SUM_W-1:0] dot_next;
    assign dot_next = SUM_W'(p1_reg[0]) + SUM_W'(p1_reg[1]) + SUM_W'(p1_reg[2]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[DEPTH-2:0], s_axis_tvalid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                p1_reg[i] <= PROD_W'(r0[i]) * PROD_W'(r1[i]);
                a1_reg[i] <= r0[i];
                b1_reg[i] <= r1[i];
                a2_reg[i] <= a1_reg[i];
                b2_reg[i] <= b1_reg[i];
                ea_reg[i] <= EPROD_W'(err_reg) * EPROD_W'(b2_reg[i]);
                eb_reg[i] <= EPROD_W'(err_reg) * EPROD_W'(a2_reg[i]);
                a3_reg[i] <= a2_reg[i];
                b3_reg[i] <= b2_reg[i];
                a4_reg[i] <= sat(SUM_W'(a3_reg[i]) + rnd_f(SUM_W'(ea_reg[i])));
                b4_reg[i] <= sat(SUM_W'(b3_reg[i]) + rnd_f(SUM_W'(eb_reg[i])));
                a5_reg[i] <= a4_reg[i];
                b5_reg[i] <= b4_reg[i];
                xp_reg[i] <= PROD_W'(a4_reg[(i+1)%3]) * PROD_W'(b4_reg[(i+2)%3]);
                xn_reg[i] <= PROD_W'(a4_reg[(i+2)%3]) * PROD_W'(b4_reg[(i+1)%3]);
                a6_reg[i] <= a5_reg[i];
                b6_reg[i] <= b5_reg[i];
                c6_reg[i] <= sat(rnd_f(SUM_W'(xp_reg[i]) - SUM_W'(xn_reg[i])));
            end
            err_reg <= ERR_W'(-rnd_h(dot_next));
        end
    end

    elem_t ao [3], bo [3], co [3];

    dcmo_renorm u_ren_a (.aclk(aclk), .en(en), .v_in(a6_reg), .v_out(ao));
    dcmo_renorm u_ren_b (.aclk(aclk), .en(en), .v_in(b6_reg), .v_out(bo));
    dcmo_renorm u_ren_c (.aclk(aclk), .en(en), .v_in(c6_reg), .v_out(co));

    always_comb begin
        m_axis_tdata = '0;
        for (int i = 0; i < 3; i++) begin
            m_axis_tdata[i*ELEM_W +: ELEM_W]     = ao[i];
            m_axis_tdata[(i+3)*ELEM_W +: ELEM_W] = bo[i];
            m_axis_tdata[(i+6)*ELEM_W +: ELEM_W] = co[i];
        end
    end

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output changed under stall");
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with empty output");
    a_flow: assert property (@(posedge aclk) disable iff (!aresetn)
        s_axis_tvalid && s_axis_tready |=> vld_reg[0])
        else $error("accepted request lost");

endmodule
